// ===== src/aes128_block_cipher_assert.svh =====
// ----------------------------------------------------------------------------
// AES-128 block cipher assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef AES128_BLOCK_CIPHER_ASSERT_SVH
`define AES128_BLOCK_CIPHER_ASSERT_SVH

// Any property, checked at every rising edge outside reset.
`define AES_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, register indexes, S-box tables and GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int unsigned NumRounds = 10;
	localparam int unsigned RkIdxW    = 4;

	localparam logic CFG_KEY_HIGH = 1'b0;
	localparam logic CFG_KEY_LOW  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	// Control handed from the sequencer to every column cell.
	typedef struct packed {
		logic load;
		logic step;
		logic dec;
		logic mix_en;
	} cell_ctrl_t;

	localparam logic [2047:0] SBOX_BITS = {
		128'h637c777bf26b6fc53001672bfed7ab76,
		128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115,
		128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84,
		128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8,
		128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973,
		128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479,
		128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
		128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df,
		128'h8ca1890dbfe6426841992d0fb054bb16
	};

	localparam logic [2047:0] INV_SBOX_BITS = {
		128'h52096ad53036a538bf40a39e81f3d7fb,
		128'h7ce339829b2fff87348e4344c4dee9cb,
		128'h547b9432a6c2233dee4c950b42fac34e,
		128'h082ea16628d924b2765ba2496d8bd125,
		128'h72f8f66486689816d4a45ccc5d65b692,
		128'h6c704850fdedb9da5e154657a78d9d84,
		128'h90d8ab008cbcd30af7e45805b8b34506,
		128'hd02c1e8fca3f0f02c1afbd0301138a6b,
		128'h3a9111414f67dcea97f2cfcef0b4e673,
		128'h96ac7422e7ad3585e2f937e81c75df6e,
		128'h47f11a711d29c5896fb7620eaa18be1b,
		128'hfc563e4bc6d279209adbc0fe78cd5af4,
		128'h1fdda8338807c731b11210592780ec5f,
		128'h60517fa919b54a0d2de57a9f93c99cef,
		128'ha0e03b4dae2af5b0c8ebbb3c83539961,
		128'h172b047eba77d626e169146355210c7d
	};

	// Table byte x sits at the top for x = 0, so the offset is (255 - x) * 8.
	function automatic logic [7:0] sbox(input logic [7:0] x);
		return SBOX_BITS[{~x, 3'b000} +: 8];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] x);
		return INV_SBOX_BITS[{~x, 3'b000} +: 8];
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	function automatic logic [7:0] rcon(input logic [RkIdxW-1:0] n);
		logic [7:0] v;
		case (n)
			4'd1:    v = 8'h01;
			4'd2:    v = 8'h02;
			4'd3:    v = 8'h04;
			4'd4:    v = 8'h08;
			4'd5:    v = 8'h10;
			4'd6:    v = 8'h20;
			4'd7:    v = 8'h40;
			4'd8:    v = 8'h80;
			4'd9:    v = 8'h1b;
			4'd10:   v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

// ===== src/aes128_block_cipher.sv =====
// ----------------------------------------------------------------------------
// AES-128 block cipher
// FIPS-197 encryption and decryption of one 128-bit block per item.
// ----------------------------------------------------------------------------
// The accepting edge loads the block, XORed with the first round key, into
// four column cells. The cells then run the ten rounds in ST_RUN, one round
// per step, and ST_DRAIN moves the block into the output register. The cells
// are free again once the block has left them, so a new item can be accepted
// while a result still waits, but not while an item is still in the cells.
// A result that is not taken keeps the next finished block in the cells.
// After reset and after every key write the schedule is expanded one round
// key a cycle, and no item is accepted until it is done.
// tuser carries func (0 encrypt, 1 decrypt).
// ----------------------------------------------------------------------------
module aes128_block_cipher (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // data_high [63:0], data_low [127:64]
	input  logic         s_axis_tuser,  // func [0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // result_high [63:0], result_low [127:64]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [63:0]  cfg_data
);

	aes_pkg::state_t            state_q, state_d;
	logic [aes_pkg::RkIdxW-1:0] rc_q;
	logic                       dec_q;
	logic                       out_valid_q;
	logic [127:0]               out_q;
	logic                       ks_ready;
	logic [aes_pkg::RkIdxW-1:0] rk_idx;
	logic [127:0]               rkey;
	logic [127:0]               blk;
	logic [127:0]               blk_key;
	logic [3:0][31:0]           cols;
	logic [3:0][31:0]           shifted;
	logic                       in_acc;
	logic                       drain_go;
	aes_pkg::cell_ctrl_t        ctrl;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == aes_pkg::ST_IDLE) && ks_ready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign drain_go      = (state_q == aes_pkg::ST_DRAIN) && (!out_valid_q || m_axis_tready);

	always_comb begin
		if (state_q == aes_pkg::ST_IDLE) begin
			rk_idx = s_axis_tuser ? 4'(aes_pkg::NumRounds) : '0;
		end else begin
			rk_idx = dec_q ? 4'(aes_pkg::NumRounds) - rc_q : rc_q;
		end
	end

	aes_key_sched u_ks (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.rd_idx   (rk_idx),
		.rd_key   (rkey),
		.ready    (ks_ready)
	);

	// Column c is the word of block bytes 4c..4c+3, column 0 on top.
	assign blk     = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
	assign blk_key = blk ^ rkey;

	// Row r of column c comes from column c+r (forward) or c-r (inverse).
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				logic [1:0] src;
				src = dec_q ? 2'(c - r) : 2'(c + r);
				shifted[3-c][31-8*r -: 8] = cols[3-src][31-8*r -: 8];
			end
		end
	end

	always_comb begin
		ctrl.load   = in_acc;
		ctrl.step   = (state_q == aes_pkg::ST_RUN);
		ctrl.dec    = dec_q;
		ctrl.mix_en = (rc_q != 4'(aes_pkg::NumRounds));
	end

	for (genvar c = 0; c < 4; c++) begin : g_cell
		aes_col_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.load_col (blk_key[127-32*c -: 32]),
			.col_in   (shifted[3-c]),
			.rkey     (rkey[127-32*c -: 32]),
			.col      (cols[3-c])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			aes_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = aes_pkg::ST_RUN;
				end
			end
			aes_pkg::ST_RUN: begin
				if (rc_q == 4'(aes_pkg::NumRounds)) begin
					state_d = aes_pkg::ST_DRAIN;
				end
			end
			aes_pkg::ST_DRAIN: begin
				if (drain_go) begin
					state_d = aes_pkg::ST_IDLE;
				end
			end
			default: state_d = aes_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= aes_pkg::ST_IDLE;
			rc_q        <= '0;
			dec_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				rc_q  <= 4'd1;
				dec_q <= s_axis_tuser;
			end else if (state_q == aes_pkg::ST_RUN && rc_q != 4'(aes_pkg::NumRounds)) begin
				rc_q <= rc_q + 4'd1;
			end
			if (drain_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain_go) begin
			out_q <= {cols[1], cols[0], cols[3], cols[2]};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

// ===== src/aes_col_cell.sv =====
// ----------------------------------------------------------------------------
// AES column cell
// Holds one state column and applies one forward or inverse round per step.
// ----------------------------------------------------------------------------
module aes_col_cell (
	input  logic                clk,
	input  aes_pkg::cell_ctrl_t ctrl,
	input  logic [31:0]         load_col,
	input  logic [31:0]         col_in,
	input  logic [31:0]         rkey,
	output logic [31:0]         col
);

	logic [31:0]     col_q;
	logic [3:0][7:0] e_b;
	logic [3:0][7:0] d_b;
	logic [3:0][7:0] k_b;
	logic [3:0][7:0] fm_b;
	logic [3:0][7:0] im_b;
	logic [31:0]     nxt;

	// Row 0 is the most significant byte of a column word.
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			k_b[3-r] = rkey[31-8*r -: 8];
			e_b[3-r] = aes_pkg::sbox(col_in[31-8*r -: 8]);
			d_b[3-r] = aes_pkg::inv_sbox(col_in[31-8*r -: 8]) ^ rkey[31-8*r -: 8];
		end
		for (int r = 0; r < 4; r++) begin
			logic [7:0] a0, a1, a2, a3, x2, x4, x8;
			a0 = e_b[3-r];
			a1 = e_b[3-((r+1)%4)];
			a2 = e_b[3-((r+2)%4)];
			a3 = e_b[3-((r+3)%4)];
			fm_b[3-r] = aes_pkg::xt(a0) ^ aes_pkg::xt(a1) ^ a1 ^ a2 ^ a3;
			// Inverse matrix row: 14, 11, 13, 9.
			a0 = d_b[3-r];
			a1 = d_b[3-((r+1)%4)];
			a2 = d_b[3-((r+2)%4)];
			a3 = d_b[3-((r+3)%4)];
			x2 = aes_pkg::xt(a0);
			x4 = aes_pkg::xt(x2);
			x8 = aes_pkg::xt(x4);
			im_b[3-r] = x8 ^ x4 ^ x2;
			x2 = aes_pkg::xt(a1);
			x4 = aes_pkg::xt(x2);
			x8 = aes_pkg::xt(x4);
			im_b[3-r] = im_b[3-r] ^ x8 ^ x2 ^ a1;
			x2 = aes_pkg::xt(a2);
			x4 = aes_pkg::xt(x2);
			x8 = aes_pkg::xt(x4);
			im_b[3-r] = im_b[3-r] ^ x8 ^ x4 ^ a2;
			x2 = aes_pkg::xt(a3);
			x4 = aes_pkg::xt(x2);
			x8 = aes_pkg::xt(x4);
			im_b[3-r] = im_b[3-r] ^ x8 ^ a3;
		end
		if (ctrl.dec) begin
			nxt = ctrl.mix_en ? im_b : d_b;
		end else begin
			nxt = (ctrl.mix_en ? fm_b : e_b) ^ k_b;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			col_q <= load_col;
		end else if (ctrl.step) begin
			col_q <= nxt;
		end
	end

	assign col = col_q;

endmodule

// ===== src/aes_key_sched.sv =====
// ----------------------------------------------------------------------------
// AES key schedule
// Holds the key registers and expands them into eleven round keys.
// ----------------------------------------------------------------------------
module aes_key_sched (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic                       wr_index,
	input  logic [63:0]                wr_data,
	input  logic [aes_pkg::RkIdxW-1:0] rd_idx,
	output logic [127:0]               rd_key,
	output logic                       ready
);

	logic [63:0]                key_hi_q;
	logic [63:0]                key_lo_q;
	logic                       stale_q;
	logic                       busy_q;
	logic [aes_pkg::RkIdxW-1:0] cnt_q;
	logic [127:0]               cur_q;
	logic [127:0]               rk_q [aes_pkg::NumRounds+1];
	logic [31:0]                t_w;
	logic [127:0]               nxt;

	always_comb begin
		t_w = aes_pkg::sub_word({cur_q[23:0], cur_q[31:24]}) ^ {aes_pkg::rcon(cnt_q), 24'h0};
		nxt[127:96] = cur_q[127:96] ^ t_w;
		nxt[95:64]  = cur_q[95:64] ^ nxt[127:96];
		nxt[63:32]  = cur_q[63:32] ^ nxt[95:64];
		nxt[31:0]   = cur_q[31:0] ^ nxt[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			stale_q  <= 1'b1;
			busy_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					aes_pkg::CFG_KEY_HIGH: key_hi_q <= wr_data;
					aes_pkg::CFG_KEY_LOW:  key_lo_q <= wr_data;
					default:               ;
				endcase
				stale_q <= 1'b1;
			end else if (stale_q && !busy_q) begin
				stale_q <= 1'b0;
				busy_q  <= 1'b1;
				cnt_q   <= 4'd1;
			end
			if (busy_q) begin
				if (cnt_q == 4'(aes_pkg::NumRounds)) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!wr_en && stale_q && !busy_q) begin
			rk_q[0] <= {key_hi_q, key_lo_q};
			cur_q   <= {key_hi_q, key_lo_q};
		end else if (busy_q) begin
			rk_q[cnt_q] <= nxt;
			cur_q       <= nxt;
		end
	end

	assign rd_key = rk_q[rd_idx];
	assign ready  = !stale_q && !busy_q;

endmodule

// ===== src/aes128_block_cipher_chk.sv =====
// ----------------------------------------------------------------------------
// AES-128 block cipher port checker
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`include "aes128_block_cipher_assert.svh"

module aes128_block_cipher_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata,
	input logic         cfg_valid,
	input logic         cfg_ready
);

	// A waiting result must stay put until it is taken.
	`AES_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result item changed while stalled")

	// One item is in the cells at a time.
	`AES_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while an item is in flight")

	// A key write forces a schedule rebuild before the next item.
	`AES_ASSERT_NEXT(a_key_rebuild, cfg_valid && cfg_ready, !s_axis_tready, "item accepted before the key schedule was rebuilt")

	// The configuration port never stalls.
	`AES_ASSERT_CLK(a_cfg_ready, cfg_ready, "configuration port stalled")

endmodule

bind aes128_block_cipher aes128_block_cipher_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready)
);
